### rtl/core/psbp_pkg.sv
// Shared types, widths, codes and reset values of the packet sequence block placer.
package psbp_pkg;

  localparam int unsigned SEQ_W      = 64;
  localparam int unsigned WIN_W      = 32;
  localparam int unsigned PPB_W      = 17;
  localparam int unsigned SLOT_W     = 16;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned CAUGHT_W   = 17;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 5;

  localparam int unsigned MAX_SLOTS_DEF = 65536;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [SEQ_W-1:0] START_SEQ_RST    = SEQ_W'(1);
  localparam logic [WIN_W-1:0] START_WINDOW_RST = WIN_W'(1000);
  localparam logic [PPB_W-1:0] PPB_RST          = PPB_W'(65536);
  localparam logic             ZERO_DATA_RST    = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_FILL  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_DONE  = 3'd2,
    KIND_PRE   = 3'd3,
    KIND_SKIP  = 3'd4,
    KIND_DISC  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    REG_START_SEQ    = 2'd0,
    REG_START_WINDOW = 2'd1,
    REG_PPB          = 2'd2,
    REG_ZERO_DATA    = 2'd3
  } reg_idx_e;

  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_STOP   = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_LOCATE,
    ST_FILL,
    ST_DONE,
    ST_DIV,
    ST_DIV_WAIT,
    ST_SKIP,
    ST_WRITE,
    ST_DISC
  } back_state_e;

  typedef struct packed {
    logic [SEQ_W-1:0] start_seq;
    logic [WIN_W-1:0] start_window;
    logic [PPB_W-1:0] ppb;
    logic             zero_data;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic             in_window;
    logic [SEQ_W-1:0] seq;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t head;
  } queue_head_t;

  typedef struct packed {
    kind_e               kind;
    logic [SLOT_W-1:0]   first_slot;
    logic [COUNT_W-1:0]  count;
    logic [CAUGHT_W-1:0] caught;
    logic                write_zeros;
    logic                last;
  } res_t;

endpackage

### rtl/core/psbp_in_if.sv
// Input channel: command and sequence number beats.
interface psbp_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] seq_no;

  modport source (output valid, output cmd, output seq_no, input ready);
  modport sink   (input valid, input cmd, input seq_no, output ready);
endinterface

### rtl/core/psbp_out_if.sv
// Output channel: placement result beats.
interface psbp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] first_slot;
  logic [31:0] count;
  logic [16:0] caught;
  logic        write_zeros;
  logic        last;

  modport source (output valid, output kind, output first_slot, output count,
                  output caught, output write_zeros, output last, input ready);
  modport sink   (input valid, input kind, input first_slot, input count,
                  input caught, input write_zeros, input last, output ready);
endinterface

### rtl/core/psbp_front.sv
// Front end: accepts input beats and classifies them for the command queue.
module psbp_front (
  psbp_in_if.sink         in_i,
  input  psbp_pkg::cfg_t  cfg_i,
  input  logic            full_i,
  output logic            push_o,
  output psbp_pkg::cmd_t  entry_o
);

  logic [psbp_pkg::SEQ_W-1:0] offset;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign offset     = in_i.seq_no - cfg_i.start_seq;

  always_comb begin
    entry_o.op  = in_i.cmd ? psbp_pkg::OP_STOP : psbp_pkg::OP_PACKET;
    entry_o.seq = in_i.seq_no;
    // start window test, never wraps below start_seq
    entry_o.in_window = (in_i.seq_no >= cfg_i.start_seq) &&
                        (offset < psbp_pkg::SEQ_W'(cfg_i.start_window));
  end

endmodule

### rtl/core/psbp_queue.sv
// Short command queue between the front end and the placement engine.
module psbp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  psbp_pkg::cmd_t        entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output psbp_pkg::queue_head_t head_o
);

  localparam int unsigned PW = (psbp_pkg::QUEUE_DEPTH > 1) ?
                               $clog2(psbp_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(psbp_pkg::QUEUE_DEPTH + 1);

  psbp_pkg::cmd_t mem_q [psbp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  fill_q, fill_d;
  logic           do_push, do_pop;

  assign full_o      = (fill_q == CW'(psbp_pkg::QUEUE_DEPTH));
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && (fill_q != '0);
  assign head_o.valid = (fill_q != '0);
  assign head_o.head  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(psbp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(psbp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + CW'(1);
      2'b01:   fill_d = fill_q - CW'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### rtl/core/psbp_div.sv
// Radix-2 restoring divider: 64-bit dividend by a block length, one bit a cycle.
module psbp_div #(
  parameter int unsigned DIVISOR_W = 17
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [psbp_pkg::SEQ_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]       divisor_i,
  output logic                       done_o,
  output logic [psbp_pkg::SEQ_W-1:0] quot_o,
  output logic [DIVISOR_W-1:0]       rem_o
);

  localparam int unsigned STEP_W = $clog2(psbp_pkg::SEQ_W + 1);

  logic                       busy_q;
  logic                       done_q;
  logic [STEP_W-1:0]          step_q;
  logic [psbp_pkg::SEQ_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]       rem_q;
  logic [DIVISOR_W-1:0]       dsr_q;
  logic [DIVISOR_W:0]         trial;
  logic [DIVISOR_W:0]         trial_sub;
  logic                       ge;

  assign trial     = {rem_q, quo_q[psbp_pkg::SEQ_W-1]};
  assign trial_sub = trial - {1'b0, dsr_q};
  assign ge        = (trial >= {1'b0, dsr_q});
  assign done_o    = done_q;
  assign quot_o    = quo_q;
  assign rem_o     = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(psbp_pkg::SEQ_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // shift quotient bits in behind the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[psbp_pkg::SEQ_W-2:0], ge};
      rem_q <= ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

endmodule

### rtl/core/psbp_back.sv
// Placement engine: block state, fill, write, close and skip sequencing.
module psbp_back #(
  parameter int unsigned MAX_SLOTS = psbp_pkg::MAX_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  psbp_pkg::cfg_t        cfg_i,
  input  psbp_pkg::queue_head_t q_i,
  output logic                  q_pop_o,
  psbp_out_if.source            out_o
);

  localparam int unsigned LW    = $clog2(MAX_SLOTS + 1);
  localparam int unsigned SEQ_W = psbp_pkg::SEQ_W;

  psbp_pkg::back_state_e state_q, state_d;
  logic                           cap_q, cap_d;
  logic [SEQ_W-1:0]               bf_q, bf_d;
  logic [LW-1:0]                  span_q, span_d;
  logic [SEQ_W-1:0]               nxt_q, nxt_d;
  logic [psbp_pkg::CAUGHT_W-1:0]  caught_q, caught_d;
  logic                           adv_q, adv_d;
  logic                           closing_q, closing_d;
  logic [SEQ_W-1:0]               seq_q, seq_d;
  logic [SEQ_W-1:0]               d_q, d_d;
  logic [LW-1:0]                  tgt_q, tgt_d;
  logic [LW-1:0]                  from_q, from_d;
  logic [psbp_pkg::COUNT_W-1:0]   cnt_q, cnt_d;
  logic                           out_vld_q, out_vld_d;
  psbp_pkg::res_t                 res_q, res_d;

  logic [LW-1:0]      cfg_span;
  logic [LW-1:0]      span_p1;
  logic               out_free;
  logic               load;
  logic               pop_stop;
  logic               lt;
  logic [SEQ_W-1:0]   diff;
  logic               over;
  logic [SEQ_W-1:0]   from_full;
  logic [LW-1:0]      from_loc;
  logic [SEQ_W-1:0]   blk_off;
  logic [31:0]        tgt_wide;
  logic [31:0]        from_wide;
  logic [31:0]        len_wide;
  logic               div_start;
  logic               div_done;
  logic [SEQ_W-1:0]   div_quot;
  logic [LW-1:0]      div_rem;

  psbp_div #(.DIVISOR_W(LW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (d_q),
    .divisor_i  (span_p1),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // block length: zero taken as one, clamped to the slot capacity
  always_comb begin
    if (cfg_i.ppb == '0) begin
      cfg_span = '0;
    end else if (32'(cfg_i.ppb) > 32'(MAX_SLOTS)) begin
      cfg_span = LW'(MAX_SLOTS - 1);
    end else begin
      cfg_span = LW'(cfg_i.ppb - psbp_pkg::PPB_W'(1));
    end
  end

  assign span_p1   = span_q + LW'(1);
  assign out_free  = !out_vld_q || out_o.ready;
  assign lt        = (seq_q < bf_q);
  assign diff      = seq_q - bf_q;
  assign over      = (diff > SEQ_W'(span_q));
  assign from_full = nxt_q - bf_q;
  assign from_loc  = (nxt_q < bf_q) ? '0 : from_full[LW-1:0];
  assign blk_off   = nxt_q - bf_q;
  assign tgt_wide  = 32'(tgt_q);
  assign from_wide = 32'(from_q);
  assign len_wide  = 32'(tgt_q - from_q);
  assign pop_stop  = (state_q == psbp_pkg::ST_IDLE) && q_i.valid &&
                     (q_i.head.op == psbp_pkg::OP_STOP);

  always_comb begin
    state_d   = state_q;
    cap_d     = cap_q;
    bf_d      = bf_q;
    span_d    = span_q;
    nxt_d     = nxt_q;
    caught_d  = caught_q;
    adv_d     = adv_q;
    closing_d = closing_q;
    seq_d     = seq_q;
    d_d       = d_q;
    tgt_d     = tgt_q;
    from_d    = from_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    load      = 1'b0;
    q_pop_o   = 1'b0;
    div_start = 1'b0;

    case (state_q)
      psbp_pkg::ST_IDLE: begin
        if (q_i.valid) begin
          q_pop_o = 1'b1;
          seq_d   = q_i.head.seq;
          adv_d   = 1'b0;
          if (q_i.head.op == psbp_pkg::OP_STOP) begin
            cap_d = 1'b0;
          end else if (!cap_q) begin
            if (q_i.head.in_window) begin
              // open the first block at start_seq
              cap_d    = 1'b1;
              caught_d = '0;
              bf_d     = cfg_i.start_seq;
              span_d   = cfg_span;
              nxt_d    = cfg_i.start_seq;
              state_d  = psbp_pkg::ST_LOCATE;
            end else begin
              state_d = psbp_pkg::ST_PRE;
            end
          end else begin
            state_d = psbp_pkg::ST_LOCATE;
          end
        end
      end

      psbp_pkg::ST_PRE: begin
        if (out_free) begin
          load    = 1'b1;
          res_d   = '{kind: psbp_pkg::KIND_PRE, first_slot: '0, count: '0,
                      caught: '0, write_zeros: 1'b0, last: 1'b1};
          state_d = psbp_pkg::ST_IDLE;
        end
      end

      psbp_pkg::ST_LOCATE: begin
        d_d    = diff;
        from_d = from_loc;
        if (lt) begin
          state_d = psbp_pkg::ST_DISC;
        end else if (over) begin
          if (adv_q) begin
            state_d = psbp_pkg::ST_DIV;
          end else begin
            // close the block: fill to its end first
            tgt_d     = span_p1;
            closing_d = 1'b1;
            state_d   = psbp_pkg::ST_FILL;
          end
        end else begin
          tgt_d     = diff[LW-1:0];
          closing_d = 1'b0;
          state_d   = psbp_pkg::ST_FILL;
        end
      end

      psbp_pkg::ST_FILL: begin
        if (tgt_q > from_q) begin
          if (out_free) begin
            load    = 1'b1;
            res_d   = '{kind: psbp_pkg::KIND_FILL, first_slot: from_wide[15:0],
                        count: len_wide, caught: '0, write_zeros: 1'b0, last: 1'b0};
            state_d = closing_q ? psbp_pkg::ST_DONE : psbp_pkg::ST_WRITE;
          end
        end else begin
          state_d = closing_q ? psbp_pkg::ST_DONE : psbp_pkg::ST_WRITE;
        end
      end

      psbp_pkg::ST_DONE: begin
        if (out_free) begin
          load     = 1'b1;
          res_d    = '{kind: psbp_pkg::KIND_DONE, first_slot: '0, count: '0,
                       caught: caught_q, write_zeros: 1'b0, last: 1'b0};
          caught_d = '0;
          // advance the window to the slot after the block end
          bf_d     = bf_q + SEQ_W'(span_q) + SEQ_W'(1);
          nxt_d    = bf_q + SEQ_W'(span_q) + SEQ_W'(1);
          span_d   = cfg_span;
          adv_d    = 1'b1;
          state_d  = psbp_pkg::ST_LOCATE;
        end
      end

      psbp_pkg::ST_DIV: begin
        div_start = 1'b1;
        state_d   = psbp_pkg::ST_DIV_WAIT;
      end

      psbp_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          // jump whole blocks: new start is the packet minus its slot
          bf_d      = seq_q - SEQ_W'(div_rem);
          nxt_d     = seq_q - SEQ_W'(div_rem);
          cnt_d     = (div_quot[SEQ_W-1:32] != '0) ? '1 : div_quot[31:0];
          tgt_d     = div_rem;
          from_d    = '0;
          closing_d = 1'b0;
          state_d   = psbp_pkg::ST_SKIP;
        end
      end

      psbp_pkg::ST_SKIP: begin
        if (out_free) begin
          load    = 1'b1;
          res_d   = '{kind: psbp_pkg::KIND_SKIP, first_slot: '0, count: cnt_q,
                      caught: '0, write_zeros: 1'b0, last: 1'b0};
          state_d = psbp_pkg::ST_FILL;
        end
      end

      psbp_pkg::ST_WRITE: begin
        if (out_free) begin
          load    = 1'b1;
          res_d   = '{kind: psbp_pkg::KIND_WRITE, first_slot: tgt_wide[15:0],
                      count: '0, caught: '0, write_zeros: cfg_i.zero_data,
                      last: 1'b1};
          if (caught_q != '1) begin
            caught_d = caught_q + psbp_pkg::CAUGHT_W'(1);
          end
          nxt_d   = seq_q + SEQ_W'(1);
          state_d = psbp_pkg::ST_IDLE;
        end
      end

      psbp_pkg::ST_DISC: begin
        if (out_free) begin
          load    = 1'b1;
          res_d   = '{kind: psbp_pkg::KIND_DISC, first_slot: '0, count: '0,
                      caught: '0, write_zeros: 1'b0, last: 1'b1};
          state_d = psbp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = psbp_pkg::ST_IDLE;
      end
    endcase

    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= psbp_pkg::ST_IDLE;
      cap_q     <= 1'b0;
      bf_q      <= '0;
      span_q    <= '0;
      nxt_q     <= '0;
      caught_q  <= '0;
      adv_q     <= 1'b0;
      closing_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cap_q     <= cap_d;
      bf_q      <= bf_d;
      span_q    <= span_d;
      nxt_q     <= nxt_d;
      caught_q  <= caught_d;
      adv_q     <= adv_d;
      closing_q <= closing_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    d_q    <= d_d;
    tgt_q  <= tgt_d;
    from_q <= from_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.kind        = res_q.kind;
  assign out_o.first_slot  = res_q.first_slot;
  assign out_o.count       = res_q.count;
  assign out_o.caught      = res_q.caught;
  assign out_o.write_zeros = res_q.write_zeros;
  assign out_o.last        = res_q.last;

  a_locate_capturing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == psbp_pkg::ST_LOCATE) |-> cap_q)
    else $error("locating a packet while not capturing");

  a_write_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (res_d.kind == psbp_pkg::KIND_WRITE)) |-> (tgt_q <= span_q))
    else $error("data write slot beyond the block");

  a_stop_ends_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(cap_q) |-> $past(pop_stop))
    else $error("capture ended without a stop command");

  a_prev_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == psbp_pkg::ST_IDLE) && cap_q) |->
      (blk_off <= (SEQ_W'(span_q) + SEQ_W'(1))))
    else $error("previous sequence lies outside the open block");

endmodule

### rtl/core/packet_sequence_block_placer_core.sv
// Top level: register port, front end, command queue and placement engine.
// Result beats are registered. A prestart passes the idle and prestart states; a discard or fill
// run also passes locate; a lone data write passes locate and fill first. Commands run one at a
// time; closing adds the fill and done states and a multi-block skip waits on the 64-step divider.
// The two-entry command queue takes new beats while the engine works or the output stalls.
// Reset clears capture state, queue and output register and loads register reset values at once.
module packet_sequence_block_placer_core #(
  parameter int unsigned MAX_SLOTS = psbp_pkg::MAX_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  psbp_in_if.sink                         in_i,
  psbp_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [psbp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [psbp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [psbp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  psbp_pkg::cfg_t        cfg_q, cfg_d;
  psbp_pkg::reg_idx_e    reg_idx;
  logic                  wr_en;
  logic                  q_full;
  logic                  q_push;
  logic                  q_pop;
  psbp_pkg::cmd_t        q_entry;
  psbp_pkg::queue_head_t q_head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = psbp_pkg::reg_idx_e'(paddr[4:3]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        psbp_pkg::REG_START_SEQ:    cfg_d.start_seq    = pwdata;
        psbp_pkg::REG_START_WINDOW: cfg_d.start_window = pwdata[psbp_pkg::WIN_W-1:0];
        psbp_pkg::REG_PPB:          cfg_d.ppb          = pwdata[psbp_pkg::PPB_W-1:0];
        psbp_pkg::REG_ZERO_DATA:    cfg_d.zero_data    = pwdata[0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      psbp_pkg::REG_START_SEQ:    prdata = cfg_q.start_seq;
      psbp_pkg::REG_START_WINDOW: prdata = psbp_pkg::APB_DATA_W'(cfg_q.start_window);
      psbp_pkg::REG_PPB:          prdata = psbp_pkg::APB_DATA_W'(cfg_q.ppb);
      psbp_pkg::REG_ZERO_DATA:    prdata = psbp_pkg::APB_DATA_W'(cfg_q.zero_data);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_seq    <= psbp_pkg::START_SEQ_RST;
      cfg_q.start_window <= psbp_pkg::START_WINDOW_RST;
      cfg_q.ppb          <= psbp_pkg::PPB_RST;
      cfg_q.zero_data    <= psbp_pkg::ZERO_DATA_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  psbp_front u_front (
    .in_i    (in_i),
    .cfg_i   (cfg_q),
    .full_i  (q_full),
    .push_o  (q_push),
    .entry_o (q_entry)
  );

  psbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head)
  );

  psbp_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .q_i     (q_head),
    .q_pop_o (q_pop),
    .out_o   (out_o)
  );

endmodule
